@@ hdl/u8d_pkg.sv @@
// Shared types and constants for the UTF-8 to code point decoder.
package u8d_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned CP_W        = 21;

    localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;

    // Sequence length codes carried with each classified byte
    localparam logic [2:0] LEN_BAD = 3'd0;
    localparam logic [2:0] LEN_1   = 3'd1;
    localparam logic [2:0] LEN_2   = 3'd2;
    localparam logic [2:0] LEN_3   = 3'd3;
    localparam logic [2:0] LEN_4   = 3'd4;

    typedef struct packed {
        logic [7:0] data;
        logic [2:0] len;   // length if this byte is taken as a lead
        logic       cont;  // byte is 10xxxxxx
    } t_byte_cls;

    typedef struct packed {
        t_byte_cls cls;
        logic      eot;
    } t_item;

endpackage

@@ hdl/u8d_front.sv @@
// Front end: accepts bytes, classifies them and queues them for the back end.
module u8d_front import u8d_pkg::*; #(
    parameter int unsigned Q_DEPTH = QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_text,
    output logic       o_q_valid,
    output t_item      o_q_item,
    input  logic       i_q_pop
);

    localparam int unsigned PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

    function automatic t_byte_cls classify(input logic [7:0] b);
        t_byte_cls c;
        c.data = b;
        c.cont = (b[7:6] == 2'b10);
        if (b[7] == 1'b0) begin
            c.len = LEN_1;
        end else if (b[7:5] == 3'b110) begin
            c.len = LEN_2;
        end else if (b[7:4] == 4'b1110) begin
            c.len = LEN_3;
        end else if (b[7:3] == 5'b11110) begin
            c.len = LEN_4;
        end else begin
            c.len = LEN_BAD;
        end
        return c;
    endfunction

    t_item            r_q [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push;
    logic             pop;

    assign o_ready   = (r_count != CNT_W'(Q_DEPTH));
    assign o_q_valid = (r_count != '0);
    assign o_q_item  = r_q[r_rd_ptr];
    assign push      = i_valid && o_ready;
    assign pop       = i_q_pop && o_q_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= '{cls: classify(i_in_byte), eot: i_end_of_text};
        end
    end

endmodule

@@ hdl/u8d_back.sv @@
// Back end: byte window, one sequence judgment per cycle while busy and the output is free, output register.
module u8d_back import u8d_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  t_item           i_q_item,
    output logic            o_q_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [CP_W-1:0] o_code_point,
    output logic            o_is_replacement,
    output logic            o_last_of_run
);

    t_byte_cls       r_win [4];
    t_byte_cls       n_win [4];
    logic [2:0]      r_cnt, n_cnt;
    logic            r_eot, n_eot;
    logic            r_busy, n_busy;
    logic            r_out_valid, n_out_valid;
    logic [CP_W-1:0] r_cp;
    logic            r_repl;
    logic            r_last;

    logic            out_free;
    logic            step;
    logic [2:0]      len;
    logic            incomplete;
    logic            cont_ok;
    logic            emit;
    logic [2:0]      drop;
    logic [2:0]      new_cnt;
    t_byte_cls       nx;
    logic            nx_emit;
    logic            last;
    logic [CP_W-1:0] dec_cp;
    logic [CP_W-1:0] res_cp;
    logic            res_repl;

    assign out_free = !r_out_valid || i_ready;
    assign step     = r_busy && out_free;
    assign o_q_pop  = !r_busy && i_q_valid;

    assign len        = r_win[0].len;
    assign incomplete = (len != LEN_BAD) && (r_cnt < len);
    assign emit       = !(incomplete && !r_eot);

    always_comb begin
        unique case (len)
            LEN_2:   cont_ok = r_win[1].cont;
            LEN_3:   cont_ok = r_win[1].cont && r_win[2].cont;
            LEN_4:   cont_ok = r_win[1].cont && r_win[2].cont && r_win[3].cont;
            default: cont_ok = 1'b1;
        endcase
    end

    always_comb begin
        unique case (len)
            LEN_1:   dec_cp = {14'd0, r_win[0].data[6:0]};
            LEN_2:   dec_cp = {10'd0, r_win[0].data[4:0], r_win[1].data[5:0]};
            LEN_3:   dec_cp = {5'd0, r_win[0].data[3:0], r_win[1].data[5:0],
                               r_win[2].data[5:0]};
            default: dec_cp = {r_win[0].data[2:0], r_win[1].data[5:0],
                               r_win[2].data[5:0], r_win[3].data[5:0]};
        endcase
    end

    always_comb begin
        if (len == LEN_BAD) begin
            drop = 3'd1;
        end else if (incomplete) begin
            drop = r_cnt;             // truncated at end of text: flush window
        end else if (cont_ok) begin
            drop = len;
        end else begin
            drop = 3'd1;              // bad continuation: rescan after the lead
        end
    end

    assign res_repl = (len == LEN_BAD) || incomplete || !cont_ok;
    assign res_cp   = res_repl ? REPL_CP : dec_cp;
    assign new_cnt  = r_cnt - drop;

    // Lookahead at the next lead to tell whether this result closes the run
    always_comb begin
        case (drop)
            3'd1:    nx = r_win[1];
            3'd2:    nx = r_win[2];
            3'd3:    nx = r_win[3];
            default: nx = r_win[0];
        endcase
    end

    assign nx_emit = (nx.len == LEN_BAD) || (new_cnt >= nx.len) || r_eot;
    assign last    = (new_cnt == 3'd0) || !nx_emit;

    always_comb begin
        n_win       = r_win;
        n_cnt       = r_cnt;
        n_eot       = r_eot;
        n_busy      = r_busy;
        n_out_valid = r_out_valid && !i_ready;
        if (o_q_pop) begin
            n_win[r_cnt[1:0]] = i_q_item.cls;
            n_cnt             = r_cnt + 3'd1;
            n_eot             = i_q_item.eot;
            n_busy            = 1'b1;
        end else if (step) begin
            if (!emit) begin
                n_busy = 1'b0;
            end else begin
                n_out_valid = 1'b1;
                n_cnt       = new_cnt;
                n_busy      = !last;
                case (drop)
                    3'd1: begin
                        n_win[0] = r_win[1];
                        n_win[1] = r_win[2];
                        n_win[2] = r_win[3];
                    end
                    3'd2: begin
                        n_win[0] = r_win[2];
                        n_win[1] = r_win[3];
                    end
                    3'd3: begin
                        n_win[0] = r_win[3];
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_eot       <= 1'b0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt       <= n_cnt;
            r_eot       <= n_eot;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
        if (step && emit) begin
            r_cp   <= res_cp;
            r_repl <= res_repl;
            r_last <= last;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_code_point     = r_cp;
    assign o_is_replacement = r_repl;
    assign o_last_of_run    = r_last;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4)
        else $error("window count out of range");

    a_idle_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_cnt <= 3'd3)
        else $error("idle window holds a full sequence");

    a_hold_not_eot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && !emit) |-> !r_eot)
        else $error("held bytes at end of text");

    a_eot_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && emit && last && r_eot) |=> (r_cnt == 3'd0))
        else $error("window not empty after end of text");

    a_no_pop_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> $stable(r_cp) && $stable(r_last))
        else $error("stalled result changed");

endmodule

@@ hdl/utf8_to_codepoint_decoder_unit.sv @@
// UTF-8 to code point decoder, top level.
// A byte goes from the queue into the back-end window only while the back end is idle.
// It then gives every result that byte causes (1 to 4), or none, before it takes the next;
// the back end judges once per cycle while its output register is free.
// The input queue takes bytes while the back end works; output stalls hold it.
// Reset (i_rst_n low, synchronous) empties the queue, window and output register.
module utf8_to_codepoint_decoder_unit import u8d_pkg::*; #(
    parameter int unsigned Q_DEPTH = QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_in_byte,
    input  logic            i_end_of_text,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [CP_W-1:0] o_code_point,
    output logic            o_is_replacement,
    output logic            o_last_of_run
);

    logic  q_valid;
    t_item q_item;
    logic  q_pop;

    u8d_front #(
        .Q_DEPTH (Q_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_in_byte     (i_in_byte),
        .i_end_of_text (i_end_of_text),
        .o_q_valid     (q_valid),
        .o_q_item      (q_item),
        .i_q_pop       (q_pop)
    );

    u8d_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_q_item         (q_item),
        .o_q_pop          (q_pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_code_point     (o_code_point),
        .o_is_replacement (o_is_replacement),
        .o_last_of_run    (o_last_of_run)
    );

endmodule
